>>> hdl/iidl_pkg.sv
`default_nettype none

package iidl_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 8;

    localparam logic [OP_W-1:0] OP_READ = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    localparam logic [DATA_W-1:0] READ_INVALID = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_RDW,
        S_SHIFT,
        S_FLUSH,
        S_WRV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [DATA_W-1:0] wdata;
    } t_wr_ctl;

endpackage

`default_nettype wire

>>> hdl/iidl_mem.sv
`default_nettype none

module iidl_mem #(
    parameter int DEPTH = 64
) (
    input  wire                            i_clk,
    input  wire iidl_pkg::t_wr_ctl         i_wr,
    input  wire  [$clog2(DEPTH)-1:0]       i_waddr,
    input  wire  [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [iidl_pkg::DATA_W-1:0]    o_rdata
);
    import iidl_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/indexed_insert_delete_list.sv
// Ordered list of up to CAPACITY signed 32-bit values, one command per request.
// Input channel: i_in_valid / o_in_ready carry op, position and value.
// Output channel: o_out_valid / i_out_ready carry read_value, done_res,
// full_refused and the list length after the command.
// One request is worked at a time; o_in_ready is high only while idle.
// Entries live in a single-port-write, registered-read RAM; inserts and
// deletes move entries one place per cycle through that RAM.
// Each request goes from S_IDLE through its states to S_DONE, where its
// result is loaded into the output register: a read in range via S_RD and
// S_RDW; an insert at the end via S_WRV; an insert moving entries via
// S_SHIFT, S_FLUSH and S_WRV; a delete moving entries via S_SHIFT and
// S_FLUSH; a delete of the last entry, an ignored, refused or out of range
// request and an unused op go straight to S_DONE. The longest request is an
// insert at the head of a list one short of full.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished second request holds in its
// final state until the output register frees.
// Synchronous active-low reset empties the list and drops any pending result;
// RAM contents are left as they are.
`default_nettype none

module indexed_insert_delete_list #(
    parameter int CAPACITY = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  wire  [iidl_pkg::OP_W-1:0]              i_op,
    input  wire  signed [iidl_pkg::POS_W-1:0]      i_position,
    input  wire  signed [iidl_pkg::DATA_W-1:0]     i_value,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output logic signed [iidl_pkg::DATA_W-1:0]     o_read_value,
    output logic                                   o_done_res,
    output logic                                   o_full_refused,
    output logic [$clog2(CAPACITY+1)-1:0]          o_length
);
    import iidl_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state r_state, n_state;

    logic [CW-1:0]     r_count;
    logic              r_ovalid;
    logic              r_pv;
    logic [AW-1:0]     r_wa;
    logic [AW-1:0]     r_src;
    logic [AW-1:0]     r_last;
    logic              r_up;
    logic [AW-1:0]     r_p;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_rd;
    logic              r_dn;
    logic              r_rf;

    logic [DATA_W-1:0] w_rdata;
    t_wr_ctl           w_wr;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;

    logic              w_accept;
    logic              w_out_free;

    // request decode
    logic              pos_neg;
    logic [CMPW-1:0]   posw;
    logic [CMPW-1:0]   cnt;
    logic [CMPW-1:0]   pi;
    logic              rd_ok;
    logic              full;
    t_state            d_next;
    logic [AW-1:0]     d_p;
    logic [AW-1:0]     d_src;
    logic [AW-1:0]     d_last;
    logic              d_up;
    logic [DATA_W-1:0] d_rd;
    logic              d_dn;
    logic              d_rf;
    logic              d_inc;
    logic              d_dec;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        pos_neg = i_position[POS_W-1];
        posw    = CMPW'(i_position[POS_W-2:0]);
        cnt     = CMPW'(r_count);
        rd_ok   = !pos_neg && (posw < cnt);
        full    = (r_count == CW'(CAPACITY));
        pi      = '0;
        d_next  = S_DONE;
        d_p     = AW'(posw);
        d_src   = '0;
        d_last  = '0;
        d_up    = 1'b0;
        d_rd    = '0;
        d_dn    = 1'b0;
        d_rf    = 1'b0;
        d_inc   = 1'b0;
        d_dec   = 1'b0;
        unique case (i_op)
            OP_READ: begin
                if (rd_ok) begin
                    d_dn   = 1'b1;
                    d_next = S_RD;
                end else begin
                    d_rd = READ_INVALID;
                end
            end
            OP_HEAD, OP_TAIL, OP_AT: begin
                if (i_op == OP_TAIL) begin
                    pi = cnt;
                end else if (i_op == OP_AT && !pos_neg) begin
                    pi = posw;
                end
                if (pi <= cnt) begin
                    if (full) begin
                        d_rf = 1'b1;
                    end else begin
                        d_dn   = 1'b1;
                        d_inc  = 1'b1;
                        d_p    = AW'(pi);
                        d_src  = AW'(cnt - CMPW'(1));
                        d_last = AW'(pi);
                        d_up   = 1'b1;
                        d_next = (pi == cnt) ? S_WRV : S_SHIFT;
                    end
                end
            end
            OP_DEL: begin
                if (rd_ok) begin
                    d_dn   = 1'b1;
                    d_dec  = 1'b1;
                    d_src  = AW'(posw + CMPW'(1));
                    d_last = AW'(cnt - CMPW'(1));
                    d_next = (posw == cnt - CMPW'(1)) ? S_DONE : S_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = d_next;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_DONE;
            S_SHIFT: if (r_src == r_last) n_state = S_FLUSH;
            S_FLUSH: n_state = r_up ? S_WRV : S_DONE;
            S_WRV:   n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_wr.we    = r_pv || (r_state == S_WRV);
        w_wr.wdata = r_pv ? w_rdata : r_val;
        w_waddr    = r_pv ? r_wa : r_p;
        w_raddr    = (r_state == S_RD) ? r_p : r_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SHIFT);
            if (w_accept && d_inc) begin
                r_count <= r_count + CW'(1);
            end else if (w_accept && d_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val  <= i_value;
            r_p    <= d_p;
            r_src  <= d_src;
            r_last <= d_last;
            r_up   <= d_up;
            r_rd   <= d_rd;
            r_dn   <= d_dn;
            r_rf   <= d_rf;
        end
        if (r_state == S_SHIFT) begin
            r_wa <= r_up ? r_src + AW'(1) : r_src - AW'(1);
            if (r_src != r_last) begin
                r_src <= r_up ? r_src - AW'(1) : r_src + AW'(1);
            end
        end
        if (r_state == S_RDW) begin
            r_rd <= w_rdata;
        end
        if (r_state == S_DONE && w_out_free) begin
            o_read_value   <= r_rd;
            o_done_res     <= r_dn;
            o_full_refused <= r_rf;
            o_length       <= r_count;
        end
    end

    assign o_out_valid = r_ovalid;

    iidl_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/iidl_chk.sv
`default_nettype none

module iidl_chk #(
    parameter int CAPACITY = 64
) (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_in_valid,
    input wire                                 o_in_ready,
    input wire                                 o_out_valid,
    input wire                                 i_out_ready,
    input wire [iidl_pkg::DATA_W-1:0]          o_read_value,
    input wire                                 o_done_res,
    input wire                                 o_full_refused,
    input wire [$clog2(CAPACITY+1)-1:0]        o_length
);
    import iidl_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_done_res) && $stable(o_full_refused) && $stable(o_length))
        else $error("result changed while stalled");

    a_refused_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_refused |-> !o_done_res && o_length == CW'(CAPACITY))
        else $error("refusal without a full list");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_length <= CW'(CAPACITY))
        else $error("length beyond capacity");

endmodule

bind indexed_insert_delete_list iidl_chk #(
    .CAPACITY (CAPACITY)
) u_iidl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_read_value   (o_read_value),
    .o_done_res     (o_done_res),
    .o_full_refused (o_full_refused),
    .o_length       (o_length)
);

`default_nettype wire
